// ===== rtl/core/wxm_pkg.sv =====
// shared types and constants for the windowed xyz mean block
package wxm_pkg;

  localparam int SUM_W  = 48;
  localparam int CNT_W  = 11;
  localparam int ERR_W  = 16;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_MEAN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HELD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERR = 2'd2;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_LAG    = 3'd2;
  localparam logic [2:0] REG_CLIM   = 3'd3;
  localparam logic [2:0] REG_TLIM   = 3'd4;
  localparam logic [2:0] REG_SINGLE = 3'd5;
  localparam logic [2:0] REG_FIRST  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_OUT
  } state_t;

  // request to the serial divider and its answer
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/wxm_div.sv =====
// serial restoring divider: signed sum over count*256, divided as a magnitude with the sign restored
module wxm_div (
  input  logic             clk,
  input  logic             rst_n,
  input  wxm_pkg::div_req_t req,
  output wxm_pkg::div_rsp_t rsp
);
  import wxm_pkg::*;

  localparam int DEN_W = CNT_W + 8;
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    trial;
  logic [SUM_W-1:0]  mag;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mag = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    trial = {rem_r[DEN_W-1:0], quo_r[SUM_W-1]};
    if (req.start) begin
      quo_nxt = mag;
      rem_nxt = '0;
      den_nxt = {(req.count > 1 ? req.count : CNT_W'(1)), 8'd0};
      neg_nxt = req.dividend[SUM_W-1];
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

  ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("divider done while busy");
  ap_busy_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != '0) else $error("divider busy with zero steps");
  ap_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(req.start) |-> rem_r < {1'b0, den_r})
    else $error("remainder out of range");
endmodule

// ===== rtl/core/windowed_xyz_mean_with_hold_top.sv =====
// top level of the windowed xyz mean with hold block
// A request is one accelerometer poll. A poll that does not close its window ends without a
// divide; a closing poll runs the three axis divides through one shared serial divider, each
// with a start, 48 quotient steps, done and store. One shared multiply-add unit handles the
// three axes one after another. The block takes one request at a time; in_stall is high while
// it works and while a result waits on the output. A timing error gives result_kind 2 with
// zero means. Writing first_target_time also loads the running target time.
module windowed_xyz_mean_with_hold_top #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 24,
  parameter int TIME_BITS   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [47:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_read_ok,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  input  logic [TIME_BITS-1:0]   in_now_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_mean_x,
  output logic signed [SAMPLE_BITS-1:0] out_mean_y,
  output logic signed [SAMPLE_BITS-1:0] out_mean_z,
  output logic [TIME_BITS-1:0]   out_stamp_time,
  output logic [wxm_pkg::CNT_W-1:0]  out_sample_count,
  output logic [wxm_pkg::KIND_W-1:0] out_result_kind
);
  import wxm_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SMP_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SUM_W-1:0] SMP_MIN = -SMP_MAX - 1;

  // configuration
  logic [31:0]          window_r;
  logic [15:0]          gain_r;
  logic [31:0]          lag_r;
  logic [ERR_W-1:0]     clim_r, tlim_r;
  logic                 single_r;

  // state
  state_t               st_r, st_nxt;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SAMPLE_BITS-1:0] held_r [3];
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS-1:0] held_time_r, target_r;
  logic [ERR_W:0]       cerr_r, terr_r;
  logic                 open_r;

  // captured request
  logic                 ok_r;
  logic signed [SAMPLE_BITS-1:0] smp_r [3];
  logic [TIME_BITS-1:0] now_r;
  logic [1:0]           ax_r;
  logic signed [SUM_W-1:0] prod_r;
  logic                 take_r;

  // result
  logic                 ov_r;
  logic signed [SAMPLE_BITS-1:0] om_r [3];
  logic [TIME_BITS-1:0] ostamp_r;
  logic [CNT_W-1:0]     ocnt_r;
  logic [KIND_W-1:0]    okind_r;

  div_req_t dreq;
  div_rsp_t drsp;

  wxm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic                 in_acc;
  logic signed [SUM_W:0] sum_ext;
  logic signed [SUM_W-1:0] sat_sum, q;
  logic signed [SAMPLE_BITS-1:0] qsat;
  logic                 ahead;
  logic [TIME_BITS-1:0] gap, stamp;
  logic [ERR_W:0]       cerr_inc, terr_inc;
  logic                 c_over, t_over;
  logic                 bump_terr, win_stay, lag_terr;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || ov_r;

  assign cerr_inc = cerr_r + 1'b1;
  assign terr_inc = terr_r + 1'b1;
  assign c_over   = cerr_inc > {1'b0, clim_r};
  assign t_over   = terr_inc > {1'b0, tlim_r};
  assign bump_terr = c_over || t_over;

  assign ahead = target_r > now_r;
  assign gap   = ahead ? target_r - now_r : now_r - target_r;
  assign stamp = (now_r < held_time_r) ? held_time_r + TIME_BITS'(window_r) : now_r;
  assign win_stay = ahead && gap < TIME_BITS'(lag_r) && now_r > held_time_r;
  assign lag_terr = gap > TIME_BITS'(lag_r);

  assign sum_ext = {sum_r[ax_r][SUM_W-1], sum_r[ax_r]} + {prod_r[SUM_W-1], prod_r};
  always_comb begin
    if (sum_ext > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) sat_sum = SUM_MAX;
    else if (sum_ext < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) sat_sum = SUM_MIN;
    else sat_sum = sum_ext[SUM_W-1:0];
    q = drsp.quotient;
    if (q > SMP_MAX) qsat = SAMPLE_BITS'(SMP_MAX);
    else if (q < SMP_MIN) qsat = SAMPLE_BITS'(SMP_MIN);
    else qsat = q[SAMPLE_BITS-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    dreq.start = 1'b0;
    dreq.dividend = sum_r[ax_r];
    dreq.count = cnt_r;
    case (st_r)
      ST_IDLE:     if (in_acc) st_nxt = ST_START;
      ST_START:    st_nxt = (!open_r && held_time_r > target_r) ? ST_IDLE : ST_MUL;
      ST_MUL:      st_nxt = ST_ADD;
      ST_ADD:      st_nxt = (ax_r == 2'd2) ? ST_CHECK : ST_MUL;
      ST_CHECK:    st_nxt = (!(take_r && !ok_r && bump_terr) && !win_stay && !lag_terr)
                            ? ST_DIV_INIT : ST_IDLE;
      ST_DIV_INIT: begin
        dreq.start = 1'b1;
        st_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN:  if (drsp.done) st_nxt = ST_DIV_DONE;
      ST_DIV_DONE: st_nxt = (ax_r == 2'd2) ? ST_OUT : ST_DIV_INIT;
      ST_OUT:      st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      window_r <= 32'd20000;
      gain_r <= 16'd256;
      lag_r <= 32'd500000;
      clim_r <= 16'd25;
      tlim_r <= 16'd1000;
      single_r <= 1'b0;
      target_r <= '0;
      held_time_r <= '0;
      cnt_r <= '0;
      cerr_r <= '0;
      terr_r <= '0;
      open_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        held_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: window_r <= cfg_data[31:0];
          REG_GAIN:   gain_r <= cfg_data[15:0];
          REG_LAG:    lag_r <= cfg_data[31:0];
          REG_CLIM:   clim_r <= cfg_data[15:0];
          REG_TLIM:   tlim_r <= cfg_data[15:0];
          REG_SINGLE: single_r <= cfg_data[0];
          REG_FIRST:  target_r <= TIME_BITS'(cfg_data);
          default:    ;
        endcase
      end
      case (st_r)
        ST_IDLE: if (in_acc) begin
          ok_r <= in_read_ok;
          smp_r[0] <= in_accel_x;
          smp_r[1] <= in_accel_y;
          smp_r[2] <= in_accel_z;
          now_r <= in_now_time;
        end
        ST_START: begin
          ax_r <= 2'd0;
          if (!open_r) begin
            for (int i = 0; i < 3; i++) sum_r[i] <= '0;
            cnt_r <= '0;
            if (held_time_r > target_r) begin
              held_time_r <= now_r;
              if (bump_terr) begin
                cerr_r <= '0;
                terr_r <= '0;
                target_r <= now_r + TIME_BITS'(window_r);
                om_r[0] <= '0; om_r[1] <= '0; om_r[2] <= '0;
                ostamp_r <= now_r;
                ocnt_r <= '0;
                okind_r <= KIND_TERR;
              end else begin
                cerr_r <= cerr_inc;
                terr_r <= terr_inc;
                target_r <= target_r + TIME_BITS'(window_r);
                om_r <= held_r;
                ostamp_r <= target_r;
                ocnt_r <= '0;
                okind_r <= KIND_HELD;
              end
              ov_r <= 1'b1;
            end else begin
              open_r <= 1'b1;
              take_r <= 1'b1;
            end
          end else begin
            take_r <= single_r ? (cnt_r == '0) : (cnt_r < CNT_W'(MAX_SAMPLES));
          end
        end
        ST_MUL: begin
          if (!open_r && take_r) take_r <= 1'b1;
          if (take_r && !single_r && cnt_r >= CNT_W'(MAX_SAMPLES)) take_r <= 1'b0;
          if (take_r && single_r && cnt_r != '0) take_r <= 1'b0;
          // shared multiplier, one axis per pass
          prod_r <= ok_r ? SUM_W'($signed(smp_r[ax_r]) * $signed({1'b0, gain_r}))
                         : SUM_W'($signed(held_r[ax_r]) * 17'sd256);
        end
        ST_ADD: begin
          if (take_r) sum_r[ax_r] <= sat_sum;
          if (ax_r != 2'd2) ax_r <= ax_r + 1'b1;
        end
        ST_CHECK: begin
          ax_r <= 2'd0;
          if (take_r && !ok_r && bump_terr) begin
            cerr_r <= '0; terr_r <= '0;
            target_r <= now_r + TIME_BITS'(window_r);
            open_r <= 1'b0;
            om_r[0] <= '0; om_r[1] <= '0; om_r[2] <= '0;
            ostamp_r <= now_r;
            ocnt_r <= cnt_r;
            okind_r <= KIND_TERR;
            ov_r <= 1'b1;
          end else if (!win_stay && lag_terr) begin
            cerr_r <= '0; terr_r <= '0;
            target_r <= now_r + TIME_BITS'(window_r);
            open_r <= 1'b0;
            om_r[0] <= '0; om_r[1] <= '0; om_r[2] <= '0;
            ostamp_r <= now_r;
            ocnt_r <= take_r ? cnt_r + 1'b1 : cnt_r;
            okind_r <= KIND_TERR;
            ov_r <= 1'b1;
          end else if (take_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (!ok_r) begin
              cerr_r <= cerr_inc;
              terr_r <= terr_inc;
            end
          end
        end
        ST_DIV_DONE: begin
          om_r[ax_r] <= qsat;
          held_r[ax_r] <= qsat;
          ax_r <= ax_r + 1'b1;
        end
        ST_OUT: begin
          held_time_r <= stamp;
          ostamp_r <= stamp;
          ocnt_r <= cnt_r;
          okind_r <= KIND_MEAN;
          cerr_r <= '0;
          target_r <= target_r + TIME_BITS'(window_r);
          open_r <= 1'b0;
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_mean_x = om_r[0];
  assign out_mean_y = om_r[1];
  assign out_mean_z = om_r[2];
  assign out_stamp_time = ostamp_r;
  assign out_sample_count = ocnt_r;
  assign out_result_kind = okind_r;

  ap_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> in_stall) else $error("request taken while busy");
  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES)) else $error("count past limit");
  ap_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (okind_r == KIND_MEAN || okind_r == KIND_HELD || okind_r == KIND_TERR))
    else $error("bad result kind");
endmodule

// ===== dv/tb.sv =====
// testbench for the windowed xyz mean with hold block
`timescale 1ns / 100ps

module tb;
  import wxm_pkg::*;

  localparam int MAXS = 64;
  localparam int N_RANDOM = 1600;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [23:0] mx, my, mz;
    logic [47:0] stamp;
    logic [10:0] cnt;
    logic [1:0] kind;
  } window_result_t;

  // predictor of the block plus queue of pending window results
  class window_scoreboard;
    logic [31:0] win_ticks, lag_lim;
    logic [15:0] gain_q88, clim, tlim;
    bit single;
    logic signed [47:0] sums [3];
    int unsigned polls;
    logic signed [23:0] held [3];
    logic [47:0] held_t, target;
    int unsigned consec, total;
    bit open;
    window_result_t pending [$];
    int errors;
    int n_mean, n_held, n_terr;

    function new();
      win_ticks = 20000; gain_q88 = 256; lag_lim = 500000;
      clim = 25; tlim = 1000; single = 0; target = '0;
      for (int i = 0; i < 3; i++) begin
        sums[i] = 0; held[i] = 0;
      end
      polls = 0; held_t = '0; consec = 0; total = 0; open = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        REG_WINDOW: win_ticks = v[31:0];
        REG_GAIN:   gain_q88 = v[15:0];
        REG_LAG:    lag_lim = v[31:0];
        REG_CLIM:   clim = v[15:0];
        REG_TLIM:   tlim = v[15:0];
        REG_SINGLE: single = v[0];
        REG_FIRST:  target = v;
        default: ;
      endcase
    endfunction

    function bit bump();
      consec++;
      if (consec > clim) return 1;
      total++;
      return total > tlim;
    endfunction

    function void push(logic signed [23:0] x, y, z, logic [47:0] st,
                       int unsigned c, logic [1:0] k);
      window_result_t r;
      r.mx = x; r.my = y; r.mz = z; r.stamp = st; r.cnt = c[10:0]; r.kind = k;
      pending.push_back(r);
      if (k == KIND_MEAN) n_mean++;
      else if (k == KIND_HELD) n_held++;
      else n_terr++;
    endfunction

    function void timing_err(logic [47:0] now);
      consec = 0; total = 0;
      target = now + {16'd0, win_ticks};
      open = 0;
      push(0, 0, 0, now, polls, KIND_TERR);
    endfunction

    function void note_poll(bit ok, logic signed [23:0] ax, ay, az,
                            logic [47:0] now);
      logic signed [63:0] smp [3];
      logic signed [63:0] acc, q;
      logic [47:0] gap, stamp;
      longint divisor;
      bit ahead, take;
      logic signed [23:0] m [3];
      smp[0] = ax; smp[1] = ay; smp[2] = az;
      if (!open) begin
        for (int i = 0; i < 3; i++) sums[i] = 0;
        polls = 0;
        if (held_t > target) begin
          held_t = now;
          if (bump()) begin
            timing_err(now);
            return;
          end
          stamp = target;
          target = target + {16'd0, win_ticks};
          push(held[0], held[1], held[2], stamp, 0, KIND_HELD);
          return;
        end
        open = 1;
      end
      take = single ? (polls == 0) : (polls < MAXS);
      if (take) begin
        for (int i = 0; i < 3; i++) begin
          acc = sums[i] + (ok ? smp[i] * $signed({48'd0, gain_q88})
                              : 64'(held[i]) * 256);
          if (acc > 64'sh7FFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF;
          if (acc < -64'sh8000_0000_0000) acc = -64'sh8000_0000_0000;
          sums[i] = acc[47:0];
        end
        if (!ok && bump()) begin
          timing_err(now);
          return;
        end
        polls++;
      end
      ahead = target > now;
      gap = ahead ? target - now : now - target;
      if (ahead && gap < {16'd0, lag_lim} && now > held_t) return;
      stamp = (now < held_t) ? held_t + {16'd0, win_ticks} : now;
      if (gap > {16'd0, lag_lim}) begin
        timing_err(now);
        return;
      end
      divisor = (polls > 1 ? longint'(polls) : 1) * 256;
      for (int i = 0; i < 3; i++) begin
        q = 64'(sums[i]) / divisor;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        m[i] = q[23:0];
        held[i] = m[i];
      end
      held_t = stamp;
      consec = 0;
      target = target + {16'd0, win_ticks};
      open = 0;
      push(m[0], m[1], m[2], stamp, polls, KIND_MEAN);
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d stamp %0d", $time, got.kind, got.stamp);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.mx !== exp_r.mx) begin
        $display("%0t: mean_x expected %0d actual %0d", $time, exp_r.mx, got.mx); errors++;
      end
      if (got.my !== exp_r.my) begin
        $display("%0t: mean_y expected %0d actual %0d", $time, exp_r.my, got.my); errors++;
      end
      if (got.mz !== exp_r.mz) begin
        $display("%0t: mean_z expected %0d actual %0d", $time, exp_r.mz, got.mz); errors++;
      end
      if (got.stamp !== exp_r.stamp) begin
        $display("%0t: stamp_time expected %0d actual %0d", $time, exp_r.stamp, got.stamp);
        errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $display("%0t: sample_count expected %0d actual %0d", $time, exp_r.cnt, got.cnt);
        errors++;
      end
      if (got.kind !== exp_r.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  logic in_valid, in_stall, in_read_ok;
  logic signed [23:0] in_accel_x, in_accel_y, in_accel_z;
  logic [47:0] in_now_time;
  logic out_valid, out_stall;
  logic signed [23:0] out_mean_x, out_mean_y, out_mean_z;
  logic [47:0] out_stamp_time;
  logic [10:0] out_sample_count;
  logic [1:0] out_result_kind;

  windowed_xyz_mean_with_hold_top u_top (.*);

  window_scoreboard sb;
  bit calm;            // no idling in the last part
  bit done;
  int idle_cycles;
  int polls_sent;
  logic [47:0] clock_now;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver with bursty stall
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 18);
      out_stall <= (burst > 0);
    end
  end

  always @(posedge clk) begin
    window_result_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.mx = out_mean_x; r.my = out_mean_y; r.mz = out_mean_z;
      r.stamp = out_stamp_time; r.cnt = out_sample_count; r.kind = out_result_kind;
      sb.check_result(r);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || done)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired");
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_poll(bit ok, logic signed [23:0] x, y, z, logic [47:0] now);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; in_read_ok <= ok;
    in_accel_x <= x; in_accel_y <= y; in_accel_z <= z; in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_poll(ok, x, y, z, now);
    polls_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  function automatic logic signed [23:0] rnd_smp();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 200)) - 24'sd100;
      default: return 24'($urandom);
    endcase
  endfunction

  // one window of polls, some with failed reads, usually closing on time
  task automatic run_window(int n);
    logic [47:0] step;
    step = 48'((sb.win_ticks / (n + 1)) + 1);
    for (int i = 0; i < n; i++) begin
      clock_now = clock_now + step;
      send_poll($urandom_range(0, 11) != 0, rnd_smp(), rnd_smp(), rnd_smp(), clock_now);
    end
    case ($urandom_range(0, 9))
      0: clock_now = clock_now - $urandom_range(1, 5000);      // time runs backwards
      1: clock_now = clock_now + sb.lag_lim + $urandom_range(1, 1000);
      2: clock_now = 48'({$urandom, $urandom});                 // noise
      default: clock_now = sb.target + $urandom_range(0, 3);
    endcase
    send_poll($urandom_range(0, 11) != 0, rnd_smp(), rnd_smp(), rnd_smp(), clock_now);
  endtask

  task automatic setup(logic [31:0] w, logic [15:0] g, logic [31:0] lag,
                       logic [15:0] cl, logic [15:0] tl, bit s, logic [47:0] first);
    write_reg(REG_WINDOW, {16'd0, w});
    write_reg(REG_GAIN, {32'd0, g});
    write_reg(REG_LAG, {16'd0, lag});
    write_reg(REG_CLIM, {32'd0, cl});
    write_reg(REG_TLIM, {32'd0, tl});
    write_reg(REG_SINGLE, {47'd0, s});
    write_reg(REG_FIRST, first);
  endtask

  initial begin
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_read_ok = 0; in_accel_x = 0; in_accel_y = 0; in_accel_z = 0;
    in_now_time = 0; calm = 0; done = 0; idle_cycles = 0; polls_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, failed reads, saturation, backwards time, held fallback
    setup(32'd1000, 16'hFFFF, 32'hFFFF_FFFF, 16'd3, 16'd5, 1'b0, 48'd1000);
    send_poll(1, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 48'd10);
    send_poll(1, 24'sh7FFFFF, 24'sh800000, 24'shFFFFFF, 48'd20);
    send_poll(1, 24'sh000000, 24'sh7FFFFF, 24'sh800000, 48'd1000);
    send_poll(0, 24'sh123456, 24'sh654321, 24'sh0F0F0F, 48'd1100);
    send_poll(0, 24'sh000000, 24'sh000000, 24'sh000000, 48'd1500);
    send_poll(1, 24'sh000010, 24'sh000020, 24'sh000030, 48'd900);  // backwards
    send_poll(1, 24'sh000001, 24'sh000001, 24'sh000001, 48'd950);  // opens a new window
    send_poll(0, 24'sh0, 24'sh0, 24'sh0, 48'd960);
    send_poll(0, 24'sh0, 24'sh0, 24'sh0, 48'd970);
    send_poll(0, 24'sh0, 24'sh0, 24'sh0, 48'd980);
    send_poll(0, 24'sh0, 24'sh0, 24'sh0, 48'd990);
    send_poll(1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 48'hFFFF_FFFF_FFFF);
    send_poll(1, 24'sh1, 24'sh2, 24'sh3, 48'hFFFF_FFFF_FFF0);
    drain();
    setup(32'd1, 16'd0, 32'd1, 16'd1, 16'd1, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_poll(1, 24'sh7FFFFF, 24'sh800000, 24'sh5, 48'hFFFF_FFFF_FFFE);
    send_poll(0, 24'sh1, 24'sh1, 24'sh1, 48'hFFFF_FFFF_FFFF);
    send_poll(1, 24'sh2, 24'sh2, 24'sh2, 48'd0);
    send_poll(1, 24'sh3, 24'sh3, 24'sh3, 48'd5);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 8; ph++) begin
      setup($urandom_range(50, 40000), (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 1024)),
            (ph == 2) ? 32'd1 : $urandom_range(5000, 600000),
            16'($urandom_range(1, 30)), (ph == 3) ? 16'hFFFF : 16'($urandom_range(2, 200)),
            (ph % 3) == 2, 48'($urandom_range(0, 100000)));
      clock_now = 0;
      if (ph == 7) calm = 1;
      while (polls_sent < 40 + (ph + 1) * N_RANDOM / 8) begin
        if ($urandom_range(0, 15) == 0) run_window($urandom_range(60, 80));
        else run_window($urandom_range(0, 8));
      end
      drain();
    end

    done = 1;
    $display("%0d polls sent; results: %0d means, %0d held fallbacks, %0d timing errors",
             polls_sent, sb.n_mean, sb.n_held, sb.n_terr);
    $display("settings covered extreme gain, lag, error limits and single-sample mode");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== windowed_xyz_mean_with_hold_top.f =====
rtl/core/wxm_pkg.sv
rtl/core/wxm_div.sv
rtl/core/windowed_xyz_mean_with_hold_top.sv
dv/tb.sv
